@@ rtl/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants for the MIDI track event parser: item kinds,
// error codes, status bytes and the decoded result record.
// ----------------------------------------------------------------------------
package mtep_pkg;

  // Default number of 7-bit groups allowed in a variable-length value.
  localparam int unsigned MAX_LENGTH_GROUPS_DEF = 4;

  // Width of the decoded variable-length values.
  localparam int unsigned VLQ_W = 28;

  // Item kinds carried on the result stream.
  localparam logic [2:0] KIND_CHANNEL = 3'd0;
  localparam logic [2:0] KIND_SYSEX   = 3'd1;
  localparam logic [2:0] KIND_META    = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG = 2'd1;
  localparam logic [1:0] ERR_STATUS   = 2'd2;

  // Status and meta bytes of interest.
  localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_CONT = 8'hF7;
  localparam logic [7:0] STATUS_META       = 8'hFF;
  localparam logic [7:0] STATUS_CHAN_LAST  = 8'hEF;
  localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
  localparam logic [3:0] HI_PROG_CHANGE    = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESSURE  = 4'hD;

  // One decoded result item.
  typedef struct packed {
    logic [2:0]       item_kind;
    logic [VLQ_W-1:0] delta_ticks;
    logic [7:0]       event_type_out;
    logic [3:0]       channel;
    logic [7:0]       first_param;
    logic [7:0]       second_param;
    logic [7:0]       meta_kind;
    logic [VLQ_W-1:0] block_length;
    logic [7:0]       payload_value;
    logic             last_of_block;
    logic             track_done;
    logic [1:0]       error_code;
  } mtep_result_t;

endpackage

@@ rtl/mtep_out_buf.sv @@
// ----------------------------------------------------------------------------
// mtep_out_buf
// Result register with a skid stage. Ready towards the parser is registered,
// so a result can be written in every cycle while the consumer keeps pace.
// ----------------------------------------------------------------------------
module mtep_out_buf
  import mtep_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  mtep_result_t push_item,
  output logic         space,
  output logic         out_valid,
  input  logic         out_ready,
  output mtep_result_t out_item
);

  logic         main_valid;
  logic         skid_valid;
  mtep_result_t main_item;
  mtep_result_t skid_item;
  logic         pop;

  assign pop       = main_valid & out_ready;
  assign space     = ~skid_valid;
  assign out_valid = main_valid;
  assign out_item  = main_item;

  // Valid flags: the skid stage only fills when the main stage is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      main_valid <= skid_valid | push;
      skid_valid <= 1'b0;
    end else if (!main_valid) begin
      main_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      main_item <= skid_valid ? skid_item : push_item;
    end else if (!main_valid) begin
      main_item <= push_item;
    end else if (push) begin
      skid_item <= push_item;
    end
  end

endmodule

@@ rtl/midi_track_event_parser_core.sv @@
// ----------------------------------------------------------------------------
// midi_track_event_parser_core
// Parses the event bytes of one MIDI track, one byte per transfer, into channel
// events, sysex and meta headers, payload bytes and error items.
// ----------------------------------------------------------------------------
// Results pass through the result register, or the skid stage on a stall, to
// the master side. Throughput: one byte per cycle while the master side keeps
// pace, set by the single pass through the phase decoder and result register.
// Reset clears the parse phase, all accumulators and running status; the
// result buffer comes out of reset empty and ready.
module midi_track_event_parser_core
  import mtep_pkg::*;
#(
  parameter int unsigned MAX_LENGTH_GROUPS = MAX_LENGTH_GROUPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,  // data_byte
  input  logic         s_tuser,  // track_start
  output logic         m_tvalid,
  input  logic         m_tready,
  // delta_ticks, event_type_out, channel, first_param, second_param,
  // meta_kind, block_length, payload_value, track_done, error_code, zero pad
  output logic [103:0] m_tdata,
  output logic [2:0]   m_tuser,  // item_kind
  output logic         m_tlast   // last_of_block
);

  localparam int unsigned GW = $clog2(MAX_LENGTH_GROUPS + 1);
  localparam logic [GW-1:0] GMAX = GW'(MAX_LENGTH_GROUPS);

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_PARAM1, PH_PARAM2, PH_MTYPE,
    PH_LENGTH, PH_PAYLOAD, PH_DONE, PH_ERROR
  } phase_t;

  phase_t           parse_phase, ph, parse_phase_next;
  logic [VLQ_W-1:0] delta_accum, dacc, delta_accum_next;
  logic [GW-1:0]    group_count, gcnt, group_count_next, gcnt_inc;
  logic [7:0]       running_status, rs, running_status_next;
  logic [7:0]       current_status, cs, current_status_next;
  logic [7:0]       held_param, hp, held_param_next;
  logic [7:0]       held_meta_kind, hmk, held_meta_kind_next;
  logic [VLQ_W-1:0] length_accum, lacc, length_accum_next;
  logic [VLQ_W-1:0] bytes_left, bytes_left_next;
  logic [VLQ_W-1:0] bl;

  logic             accept;
  logic             res_valid;
  mtep_result_t     res;
  mtep_result_t     out_item;
  logic             space;
  logic [7:0]       b;

  assign b        = s_tdata;
  assign s_tready = space;
  assign accept   = s_tvalid & s_tready;

  function automatic logic is_chan(input logic [7:0] s);
    return s[7] && (s <= STATUS_CHAN_LAST);
  endfunction

  function automatic logic two_params(input logic [7:0] s);
    return (s[7:4] != HI_PROG_CHANGE) && (s[7:4] != HI_CHAN_PRESSURE);
  endfunction

  // A track start clears the state before the byte is parsed.
  always_comb begin
    if (s_tuser) begin
      ph   = PH_DELTA;
      dacc = '0;
      gcnt = '0;
      rs   = '0;
      cs   = '0;
      hp   = '0;
      hmk  = '0;
      lacc = '0;
      bl   = '0;
    end else begin
      ph   = parse_phase;
      dacc = delta_accum;
      gcnt = group_count;
      rs   = running_status;
      cs   = current_status;
      hp   = held_param;
      hmk  = held_meta_kind;
      lacc = length_accum;
      bl   = bytes_left;
    end
  end

  assign gcnt_inc = gcnt + GW'(1);

  // Phase decoder: next state and the result for this byte.
  always_comb begin
    parse_phase_next    = ph;
    delta_accum_next    = dacc;
    group_count_next    = gcnt;
    running_status_next = rs;
    current_status_next = cs;
    held_param_next     = hp;
    held_meta_kind_next = hmk;
    length_accum_next   = lacc;
    bytes_left_next     = bl;
    res                 = '0;
    res_valid           = 1'b0;

    unique case (ph)
      PH_DELTA: begin
        delta_accum_next = {dacc[VLQ_W-8:0], b[6:0]};
        group_count_next = gcnt_inc;
        if (!b[7]) begin
          group_count_next = '0;
          parse_phase_next = PH_STATUS;
        end else if (gcnt_inc >= GMAX) begin
          parse_phase_next = PH_ERROR;
          res_valid        = 1'b1;
          res.item_kind    = KIND_ERROR;
          res.error_code   = ERR_TOO_LONG;
        end
      end

      PH_STATUS: begin
        if (b[7]) begin
          current_status_next = b;
          if (is_chan(b)) begin
            running_status_next = b;
            parse_phase_next    = PH_PARAM1;
          end else begin
            running_status_next = '0;
            if (b == STATUS_SYSEX || b == STATUS_SYSEX_CONT) begin
              length_accum_next = '0;
              group_count_next  = '0;
              parse_phase_next  = PH_LENGTH;
            end else if (b == STATUS_META) begin
              parse_phase_next = PH_MTYPE;
            end else begin
              parse_phase_next = PH_ERROR;
              res_valid        = 1'b1;
              res.item_kind    = KIND_ERROR;
              res.error_code   = ERR_STATUS;
            end
          end
        end else if (!is_chan(rs)) begin
          parse_phase_next = PH_ERROR;
          res_valid        = 1'b1;
          res.item_kind    = KIND_ERROR;
          res.error_code   = ERR_STATUS;
        end else begin
          // Running status: this byte is the first parameter.
          current_status_next = rs;
          held_param_next     = b;
          if (two_params(rs)) begin
            parse_phase_next = PH_PARAM2;
          end else begin
            res_valid          = 1'b1;
            res.item_kind      = KIND_CHANNEL;
            res.delta_ticks    = dacc;
            res.event_type_out = {rs[7:4], 4'h0};
            res.channel        = rs[3:0];
            res.first_param    = b;
            parse_phase_next   = PH_DELTA;
            delta_accum_next   = '0;
            group_count_next   = '0;
          end
        end
      end

      PH_PARAM1: begin
        held_param_next = b;
        if (two_params(cs)) begin
          parse_phase_next = PH_PARAM2;
        end else begin
          res_valid          = 1'b1;
          res.item_kind      = KIND_CHANNEL;
          res.delta_ticks    = dacc;
          res.event_type_out = {cs[7:4], 4'h0};
          res.channel        = cs[3:0];
          res.first_param    = b;
          parse_phase_next   = PH_DELTA;
          delta_accum_next   = '0;
          group_count_next   = '0;
        end
      end

      PH_PARAM2: begin
        res_valid          = 1'b1;
        res.item_kind      = KIND_CHANNEL;
        res.delta_ticks    = dacc;
        res.event_type_out = {cs[7:4], 4'h0};
        res.channel        = cs[3:0];
        res.first_param    = hp;
        res.second_param   = b;
        parse_phase_next   = PH_DELTA;
        delta_accum_next   = '0;
        group_count_next   = '0;
      end

      PH_MTYPE: begin
        held_meta_kind_next = b;
        length_accum_next   = '0;
        group_count_next    = '0;
        parse_phase_next    = PH_LENGTH;
      end

      PH_LENGTH: begin
        length_accum_next = {lacc[VLQ_W-8:0], b[6:0]};
        group_count_next  = gcnt_inc;
        if (b[7]) begin
          if (gcnt_inc >= GMAX) begin
            parse_phase_next = PH_ERROR;
            res_valid        = 1'b1;
            res.item_kind    = KIND_ERROR;
            res.error_code   = ERR_TOO_LONG;
          end
        end else begin
          // Length complete: give the block header.
          group_count_next   = '0;
          res_valid          = 1'b1;
          res.delta_ticks    = dacc;
          res.event_type_out = cs;
          res.block_length   = length_accum_next;
          if (cs == STATUS_META) begin
            res.item_kind = KIND_META;
            res.meta_kind = hmk;
          end else begin
            res.item_kind = KIND_SYSEX;
          end
          bytes_left_next  = length_accum_next;
          delta_accum_next = '0;
          if (length_accum_next != '0) begin
            parse_phase_next = PH_PAYLOAD;
          end else if (cs == STATUS_META && hmk == META_END_OF_TRACK) begin
            res.track_done   = 1'b1;
            parse_phase_next = PH_DONE;
          end else begin
            parse_phase_next = PH_DELTA;
          end
        end
      end

      PH_PAYLOAD: begin
        res_valid         = 1'b1;
        res.item_kind     = KIND_PAYLOAD;
        res.payload_value = b;
        bytes_left_next   = bl - VLQ_W'(1);
        if (bytes_left_next == '0) begin
          res.last_of_block = 1'b1;
          if (cs == STATUS_META && hmk == META_END_OF_TRACK) begin
            res.track_done   = 1'b1;
            parse_phase_next = PH_DONE;
          end else begin
            parse_phase_next = PH_DELTA;
          end
        end
      end

      PH_DONE, PH_ERROR: begin
        // Bytes are dropped until the next track start.
      end

      default: begin
      end
    endcase
  end

  // Parser state, updated on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_DELTA;
      delta_accum    <= '0;
      group_count    <= '0;
      running_status <= '0;
      current_status <= '0;
      held_param     <= '0;
      held_meta_kind <= '0;
      length_accum   <= '0;
      bytes_left     <= '0;
    end else if (accept) begin
      parse_phase    <= parse_phase_next;
      delta_accum    <= delta_accum_next;
      group_count    <= group_count_next;
      running_status <= running_status_next;
      current_status <= current_status_next;
      held_param     <= held_param_next;
      held_meta_kind <= held_meta_kind_next;
      length_accum   <= length_accum_next;
      bytes_left     <= bytes_left_next;
    end
  end

  // Result register and skid stage.
  mtep_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept & res_valid),
    .push_item (res),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  // Pack the result onto the master side.
  assign m_tuser = out_item.item_kind;
  assign m_tlast = out_item.last_of_block;
  assign m_tdata = {1'b0,
                    out_item.error_code,
                    out_item.track_done,
                    out_item.payload_value,
                    out_item.block_length,
                    out_item.meta_kind,
                    out_item.second_param,
                    out_item.first_param,
                    out_item.channel,
                    out_item.event_type_out,
                    out_item.delta_ticks};

endmodule
